### rtl/ltd_pkg.sv
// Shared types and constants of the lease task dispatcher.
`default_nettype none
package ltd_pkg;
   localparam int TASK_SLOTS = 32;
   localparam int WORKERS    = 16;

   localparam logic [2:0] OP_ENQUEUE  = 3'd0;
   localparam logic [2:0] OP_ACQUIRE  = 3'd1;
   localparam logic [2:0] OP_PROGRESS = 3'd2;
   localparam logic [2:0] OP_SUBMIT   = 3'd3;
   localparam logic [2:0] OP_SWEEP    = 3'd4;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_FULL      = 4'd1;
   localparam logic [3:0] ST_BUSY      = 4'd2;
   localparam logic [3:0] ST_NONE      = 4'd3;
   localparam logic [3:0] ST_UNKNOWN   = 4'd4;
   localparam logic [3:0] ST_DUPLICATE = 4'd5;
   localparam logic [3:0] ST_FAILED    = 4'd6;
   localparam logic [3:0] ST_MISMATCH  = 4'd7;
   localparam logic [3:0] ST_LATE      = 4'd8;
   localparam logic [3:0] ST_EXPFAIL   = 4'd9;
   localparam logic [3:0] ST_SWEEPDONE = 4'd10;

   localparam logic [1:0] SL_PENDING = 2'd0;
   localparam logic [1:0] SL_LEASED  = 2'd1;
   localparam logic [1:0] SL_DONE    = 2'd2;
   localparam logic [1:0] SL_FAILED  = 2'd3;

   localparam logic [0:0] CSR_LEASE_TICKS = 1'd0;
   localparam logic [0:0] CSR_RETRY_LIMIT = 1'd1;

   typedef struct packed {
      logic [2:0]  operation;
      logic [3:0]  worker;
      logic [4:0]  task_req;
      logic [15:0] lease_tag;
      logic [15:0] client_tag;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [4:0]  task_out;
      logic [15:0] lease_out;
      logic [15:0] client_out;
      logic [7:0]  attempt_out;
      logic [31:0] expiry_out;
      logic        last;
      logic [5:0]  pend_tally;
      logic [5:0]  lease_tally;
      logic [5:0]  done_tally;
      logic [5:0]  fail_tally;
      logic        settled;
   } rsp_type;

   typedef struct packed {
      logic [0:0]  index;
      logic [31:0] data;
   } csr_type;

   typedef enum logic [2:0] {
      EX_IDLE,
      EX_READ,
      EX_EXEC,
      EX_SWEEP_RD,
      EX_SWEEP_EX,
      EX_DONE
   } exec_state_type;
endpackage
`default_nettype wire

### rtl/ltd_if.sv
// Valid/ready channel interface used by every port of the dispatcher.
`default_nettype none
interface ltd_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/ltd_front.sv
// Front end: accepts request words, drops unused codes, queues the rest.
`default_nettype none
module ltd_front (
   input  wire logic             clock,
   input  wire logic             reset,
   ltd_if.sink                   req,
   output ltd_pkg::req_type      q_word,
   output logic                  q_valid,
   input  wire logic             q_pop
);
   ltd_pkg::req_type mem_ff [4];
   logic [1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic push, known;

   assign known = req.payload.operation <= ltd_pkg::OP_SWEEP;
   assign req.ready = cnt_ff != 3'd4;
   assign push = req.valid && req.ready && known;
   assign q_valid = cnt_ff != 3'd0;
   assign q_word = mem_ff[rd_ff];

   always_comb begin
      wr_in = push ? wr_ff + 2'd1 : wr_ff;
      rd_in = q_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, push} - {2'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= req.payload;
      end
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("queue count beyond depth");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && !known) |=> $stable(cnt_ff) || $past(q_pop))
      else $error("unused code was queued");
endmodule
`default_nettype wire

### rtl/ltd_back.sv
// Back end: slot table, pending queue, worker leases and the expiry sweep.
`default_nettype none
module ltd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ltd_pkg::req_type q_word,
   input  wire logic             q_valid,
   output logic                  q_pop,
   input  wire logic [31:0]      lease_ticks,
   input  wire logic [7:0]       retry_limit,
   ltd_if.source                 rsp
);
   localparam int TASK_SLOTS = ltd_pkg::TASK_SLOTS;
   localparam int WORKERS = ltd_pkg::WORKERS;
   localparam int SW = $clog2(TASK_SLOTS);
   localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

   // Slot record memory, read-modify-write through one registered read port.
   typedef struct packed {
      logic [1:0]  state;
      logic [15:0] client;
      logic [3:0]  holder;
      logic        holder_valid;
      logic [15:0] lease;
      logic [31:0] expiry;
      logic [7:0]  attempts;
   } slot_type;

   slot_type   slot_mem [TASK_SLOTS];
   logic [4:0] fifo_mem [TASK_SLOTS];
   slot_type   rd_slot_ff;
   logic [4:0] rd_fifo_ff;
   logic       we;
   logic [SW-1:0] wa, ra;
   slot_type   wd;
   logic       fwe;
   logic [SW-1:0] fwa;
   logic [4:0] fwd;

   logic [WORKERS-1:0] busy_ff, busy_in;
   logic [SW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [6:0]  alloc_ff, alloc_in;
   logic [15:0] ctr_ff, ctr_in;
   logic [5:0]  pend_ff, pend_in, lsd_ff, lsd_in, comp_ff, comp_in, fail_ff, fail_in;
   ltd_pkg::exec_state_type st_ff, st_in;
   logic [SW:0] sidx_ff, sidx_in;
   ltd_pkg::rsp_type out_ff, out_in;
   logic ov_ff, ov_in;
   logic emit;
   ltd_pkg::rsp_type em;
   logic [32:0] sum;
   logic [31:0] expv;
   logic [SW-1:0] slot_pick;
   logic in_t;

   assign sum = {1'b0, q_word.now} + {1'b0, lease_ticks};
   assign expv = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign in_t = {2'b0, q_word.task_req} < alloc_ff
                 && 32'(q_word.task_req) < TASK_SLOTS;
   assign slot_pick = SW'(rd_fifo_ff);

   always_ff @(posedge clock) begin
      if (we) slot_mem[wa] <= wd;
      if (fwe) fifo_mem[fwa] <= fwd;
      rd_slot_ff <= slot_mem[ra];
      rd_fifo_ff <= fifo_mem[head_ff];
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ltd_pkg::EX_IDLE: if (q_valid && !ov_ff) st_in = ltd_pkg::EX_READ;
         ltd_pkg::EX_READ: st_in = ltd_pkg::EX_EXEC;
         ltd_pkg::EX_EXEC: begin
            if (q_word.operation == ltd_pkg::OP_SWEEP) st_in = ltd_pkg::EX_SWEEP_RD;
            else st_in = ltd_pkg::EX_IDLE;
         end
         ltd_pkg::EX_SWEEP_RD: begin
            if (sidx_ff >= alloc_ff[SW:0] || 32'(sidx_ff) >= TASK_SLOTS)
               st_in = ltd_pkg::EX_DONE;
            else st_in = ltd_pkg::EX_SWEEP_EX;
         end
         ltd_pkg::EX_SWEEP_EX: if (!ov_ff) st_in = ltd_pkg::EX_SWEEP_RD;
         ltd_pkg::EX_DONE: if (!ov_ff) st_in = ltd_pkg::EX_IDLE;
         default: st_in = ltd_pkg::EX_IDLE;
      endcase
   end

   always_comb begin
      logic [SW-1:0] ti, si;
      logic [WW-1:0] wi;
      logic m, late;
      ti = SW'(q_word.task_req);
      si = sidx_ff[SW-1:0];
      wi = WW'(q_word.worker);
      m = 1'b0;
      late = 1'b0;
      busy_in = busy_ff; head_in = head_ff; tail_in = tail_ff;
      alloc_in = alloc_ff; ctr_in = ctr_ff;
      pend_in = pend_ff; lsd_in = lsd_ff; comp_in = comp_ff; fail_in = fail_ff;
      sidx_in = sidx_ff;
      we = 1'b0; wa = ti; wd = rd_slot_ff;
      fwe = 1'b0; fwa = tail_ff; fwd = '0;
      ra = ti;
      q_pop = 1'b0;
      emit = 1'b0;
      em = '0;
      em.last = 1'b1;
      unique case (st_ff)
         ltd_pkg::EX_IDLE: begin
            ra = ti;
            sidx_in = '0;
         end
         ltd_pkg::EX_READ: begin
            ra = (q_word.operation == ltd_pkg::OP_ACQUIRE) ? slot_pick : ti;
         end
         ltd_pkg::EX_EXEC: begin
            m = rd_slot_ff.holder_valid && rd_slot_ff.holder == q_word.worker
                && rd_slot_ff.lease == q_word.lease_tag;
            unique case (q_word.operation)
               ltd_pkg::OP_ENQUEUE: begin
                  emit = 1'b1;
                  if (32'(alloc_ff) >= TASK_SLOTS) em.status = ltd_pkg::ST_FULL;
                  else begin
                     we = 1'b1;
                     wa = SW'(alloc_ff);
                     wd = '0;
                     wd.state = ltd_pkg::SL_PENDING;
                     wd.client = q_word.client_tag;
                     fwe = 1'b1;
                     fwd = 5'(alloc_ff);
                     tail_in = (32'(tail_ff) == TASK_SLOTS - 1) ? '0 : tail_ff + 1'b1;
                     alloc_in = alloc_ff + 7'd1;
                     pend_in = pend_ff + 6'd1;
                     em.task_out = 5'(alloc_ff);
                  end
               end
               ltd_pkg::OP_ACQUIRE: begin
                  emit = 1'b1;
                  if (32'(q_word.worker) >= WORKERS) em.status = ltd_pkg::ST_UNKNOWN;
                  else if (busy_ff[wi]) em.status = ltd_pkg::ST_BUSY;
                  else if (pend_ff == 6'd0) em.status = ltd_pkg::ST_NONE;
                  else begin
                     head_in = (32'(head_ff) == TASK_SLOTS - 1) ? '0 : head_ff + 1'b1;
                     pend_in = pend_ff - 6'd1;
                     lsd_in = lsd_ff + 6'd1;
                     ctr_in = ctr_ff + 16'd1;
                     we = 1'b1;
                     wa = slot_pick;
                     wd.state = ltd_pkg::SL_LEASED;
                     wd.holder = q_word.worker;
                     wd.holder_valid = 1'b1;
                     wd.lease = ctr_in;
                     wd.expiry = expv;
                     if (rd_slot_ff.attempts != 8'hFF) wd.attempts = rd_slot_ff.attempts + 8'd1;
                     busy_in[wi] = 1'b1;
                     em.task_out = 5'(slot_pick);
                     em.lease_out = ctr_in;
                     em.client_out = rd_slot_ff.client;
                     em.attempt_out = wd.attempts;
                     em.expiry_out = expv;
                  end
               end
               ltd_pkg::OP_PROGRESS: begin
                  emit = 1'b1;
                  em.task_out = q_word.task_req;
                  if (!in_t) em.status = ltd_pkg::ST_UNKNOWN;
                  else if (!m) em.status = ltd_pkg::ST_MISMATCH;
               end
               ltd_pkg::OP_SUBMIT: begin
                  emit = 1'b1;
                  em.task_out = q_word.task_req;
                  late = q_word.now > rd_slot_ff.expiry;
                  if (!in_t) em.status = ltd_pkg::ST_UNKNOWN;
                  else if (rd_slot_ff.state == ltd_pkg::SL_DONE)
                     em.status = ltd_pkg::ST_DUPLICATE;
                  else if (rd_slot_ff.state == ltd_pkg::SL_FAILED)
                     em.status = ltd_pkg::ST_FAILED;
                  else if (!m) em.status = ltd_pkg::ST_MISMATCH;
                  else if (late) em.status = ltd_pkg::ST_LATE;
                  else begin
                     we = 1'b1;
                     wd.state = ltd_pkg::SL_DONE;
                     lsd_in = lsd_ff - 6'd1;
                     comp_in = comp_ff + 6'd1;
                     if (32'(q_word.worker) < WORKERS) busy_in[wi] = 1'b0;
                  end
               end
               default: begin
                  ra = '0;
               end
            endcase
            if (q_word.operation != ltd_pkg::OP_SWEEP) q_pop = 1'b1;
         end
         ltd_pkg::EX_SWEEP_RD: begin
            ra = si;
         end
         ltd_pkg::EX_SWEEP_EX: begin
            ra = si;
            if (!ov_ff) begin
               sidx_in = sidx_ff + 1'b1;
               if (rd_slot_ff.state == ltd_pkg::SL_LEASED && q_word.now > rd_slot_ff.expiry) begin
                  if (32'(rd_slot_ff.holder) < WORKERS) busy_in[WW'(rd_slot_ff.holder)] = 1'b0;
                  lsd_in = lsd_ff - 6'd1;
                  we = 1'b1;
                  wa = si;
                  if (rd_slot_ff.attempts >= retry_limit) begin
                     wd.state = ltd_pkg::SL_FAILED;
                     fail_in = fail_ff + 6'd1;
                     emit = 1'b1;
                     em.status = ltd_pkg::ST_EXPFAIL;
                     em.task_out = 5'(si);
                     em.client_out = rd_slot_ff.client;
                     em.last = 1'b0;
                  end else begin
                     wd.state = ltd_pkg::SL_PENDING;
                     wd.holder_valid = 1'b0;
                     fwe = 1'b1;
                     fwd = 5'(si);
                     tail_in = (32'(tail_ff) == TASK_SLOTS - 1) ? '0 : tail_ff + 1'b1;
                     pend_in = pend_ff + 6'd1;
                  end
               end
            end
         end
         ltd_pkg::EX_DONE: begin
            if (!ov_ff) begin
               emit = 1'b1;
               em.status = ltd_pkg::ST_SWEEPDONE;
               q_pop = 1'b1;
            end
         end
         default: begin
            ra = '0;
         end
      endcase
      em.pend_tally = pend_in;
      em.lease_tally = lsd_in;
      em.done_tally = comp_in;
      em.fail_tally = fail_in;
      em.settled = pend_in == 6'd0 && lsd_in == 6'd0;
      out_in = emit ? em : out_ff;
      ov_in = emit ? 1'b1 : (ov_ff && !rsp.ready);
   end

   assign rsp.valid = ov_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset) begin
         st_ff <= ltd_pkg::EX_IDLE;
         busy_ff <= '0; head_ff <= '0; tail_ff <= '0; alloc_ff <= '0; ctr_ff <= '0;
         pend_ff <= '0; lsd_ff <= '0; comp_ff <= '0; fail_ff <= '0;
         sidx_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         busy_ff <= busy_in; head_ff <= head_in; tail_ff <= tail_in;
         alloc_ff <= alloc_in; ctr_ff <= ctr_in;
         pend_ff <= pend_in; lsd_ff <= lsd_in; comp_ff <= comp_in; fail_ff <= fail_in;
         sidx_ff <= sidx_in; ov_ff <= ov_in;
      end
   end

   // An EXEC emit only happens with the output register empty, as IDLE waits for it.
   assert property (@(posedge clock) disable iff (reset) emit |-> (!ov_ff || rsp.ready))
      else $error("result word overwritten");
   assert property (@(posedge clock) disable iff (reset)
      32'(pend_ff) + 32'(lsd_ff) + 32'(comp_ff) + 32'(fail_ff) == 32'(alloc_ff))
      else $error("tallies disagree with allocation");
   assert property (@(posedge clock) disable iff (reset) 32'(alloc_ff) <= TASK_SLOTS)
      else $error("allocation beyond table");
endmodule
`default_nettype wire

### rtl/lease_task_dispatcher.sv
// Top level of the lease task dispatcher.
// Request words arrive on req (operation, worker, task_req, lease_tag, client_tag, now),
// result words leave on rsp, and csr writes lease_ticks (index 0) or retry_limit
// (index 1); csr is always ready and should be written only while the block is idle.
// The table holds 32 slots and serves 16 workers, both fixed in the package.
// A front queue of four words takes requests while the back end works; unused
// operation codes are dropped there and give no result.
// A table operation passes through the back end as pick-up, memory read and update,
// the update loading its result into the output register; the back end picks up
// no new request until that register has emptied.
// A sweep over n allocated slots reads and then examines each slot in turn; its
// closing word, with last set, follows the last slot, and each permanent failure
// emits one word before it. A stalled rsp holds the back end at these steps.
// When rsp stalls the back end holds in its output register; the front queue
// keeps taking requests until its four entries are full.
// Reset clears counts, worker busy flags and queue pointers; the slot memories
// need no clearing since no unwritten entry affects a result or the state.
`default_nettype none
module lease_task_dispatcher (
   input  wire logic clock,
   input  wire logic reset,
   ltd_if.sink       req,
   ltd_if.source     rsp,
   ltd_if.sink       csr
);
   ltd_pkg::req_type q_word;
   logic q_valid, q_pop;
   logic [31:0] lease_ticks_ff;
   logic [7:0] retry_limit_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lease_ticks_ff <= 32'd30;
         retry_limit_ff <= 8'd3;
      end else if (csr.valid) begin
         unique case (csr.payload.index)
            ltd_pkg::CSR_LEASE_TICKS: lease_ticks_ff <= csr.payload.data;
            ltd_pkg::CSR_RETRY_LIMIT: retry_limit_ff <= csr.payload.data[7:0];
            default: lease_ticks_ff <= lease_ticks_ff;
         endcase
      end
   end

   ltd_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_word(q_word), .q_valid(q_valid), .q_pop(q_pop)
   );

   ltd_back u_back (
      .clock(clock), .reset(reset), .q_word(q_word), .q_valid(q_valid), .q_pop(q_pop),
      .lease_ticks(lease_ticks_ff), .retry_limit(retry_limit_ff), .rsp(rsp)
   );
endmodule
`default_nettype wire
